[rtl/core/rsdt_pkg.sv]
// Shared types and constants for the RSSI-sorted device table.
// Used by rsdt_ctrl, rsdt_datapath, rssi_sorted_device_table and the verif benches; depends on nothing.
package rsdt_pkg;

  localparam int TABLE_DEPTH_DEF   = 16;
  localparam int MAX_ENTRIES_RESET = 10;

  localparam int MODE_W    = 2;
  localparam int ADDR_W    = 48;
  localparam int SIG_W     = 8;
  localparam int IDX_W     = 4;
  localparam int MAX_ENT_W = 5;
  localparam int COUNT_W   = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_REPORT = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEARCH,
    ST_PLAN,
    ST_MOVE,
    ST_PUT,
    ST_READ,
    ST_RESULT
  } state_t;

  // One table slot as stored in the slot memory.
  typedef struct packed {
    logic [ADDR_W-1:0]       address;
    logic signed [SIG_W-1:0] rssi;
    logic signed [SIG_W-1:0] tx_power;
    logic                    svc_listed;
    logic                    svc_wanted;
  } slot_t;

  // One request as taken from the input channel.
  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [ADDR_W-1:0]       address;
    logic signed [SIG_W-1:0] rssi;
    logic                    name_matches;
    logic                    tx_power_present;
    logic signed [SIG_W-1:0] tx_power;
    logic                    svc_listed;
    logic                    svc_wanted;
    logic [IDX_W-1:0]        read_index;
  } item_t;

  // One result as driven on the output channel.
  typedef struct packed {
    logic                    accepted;
    logic                    evicted;
    logic [IDX_W-1:0]        position;
    logic [COUNT_W-1:0]      entry_count;
    logic                    entry_valid;
    logic [ADDR_W-1:0]       entry_address;
    logic signed [SIG_W-1:0] entry_rssi;
    logic signed [SIG_W-1:0] entry_tx_power;
    logic                    entry_svc_listed;
    logic                    entry_svc_wanted;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan;
    logic plan;
    logic move;
    logic put;
    logic read_issue;
    logic clear;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_report;
    logic is_read;
    logic is_clear;
    logic scan_done;
    logic move_done;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/core/rsdt_ctrl.sv]
// Controller state machine of the RSSI-sorted device table.
// Depends on rsdt_pkg; drives datapath commands from datapath status.
module rsdt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rsdt_pkg::dp_sts_t sts_i,
  output rsdt_pkg::dp_cmd_t cmd_o
);
  import rsdt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (sts_i.is_report) begin
          state_nxt = ST_SEARCH;
        end else if (sts_i.is_read) begin
          state_nxt = ST_READ;
        end else if (sts_i.is_clear) begin
          cmd_o.clear = 1'b1;
          state_nxt   = ST_RESULT;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_SEARCH: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_nxt = ST_PLAN;
        end
      end
      ST_PLAN: begin
        cmd_o.plan = 1'b1;
        state_nxt  = ST_MOVE;
      end
      ST_MOVE: begin
        cmd_o.move = 1'b1;
        if (sts_i.move_done) begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        cmd_o.put = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_READ: begin
        cmd_o.read_issue = 1'b1;
        state_nxt        = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("result loaded while output register still occupied");

  a_plan_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PLAN |-> $past(state_r) == ST_SEARCH && $past(sts_i.scan_done))
    else $error("plan entered before search pass finished");

endmodule

[rtl/core/rsdt_datapath.sv]
// Datapath of the RSSI-sorted device table: slot memory, scan and move
// counters, insertion planning and the output register. Depends on rsdt_pkg.
module rsdt_datapath #(
  parameter int TABLE_DEPTH = rsdt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rsdt_pkg::dp_cmd_t                  cmd_i,
  output rsdt_pkg::dp_sts_t                  sts_o,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   limit_i,
  input  rsdt_pkg::item_t                    item_i,
  output rsdt_pkg::result_t                  result_o,
  output logic                               out_valid,
  input  logic                               out_stall
);
  import rsdt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (CW > IDX_W) ? CW : IDX_W;

  slot_t mem [TABLE_DEPTH];
  slot_t rd_data_r;

  item_t   item_r;
  result_t result_r;
  logic    out_valid_r, out_valid_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] ge_r, ge_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] mv_left_r, mv_left_nxt;
  logic [CW-1:0] chk_idx_r;
  logic [CW-1:0] dest_r, dest_nxt;
  logic          chk_vld_r, wr_pend_r;
  logic          found_r, found_nxt;
  logic          evict_r, evict_nxt;
  logic          up_r, up_nxt;
  logic          rvalid_r;
  logic signed [SIG_W-1:0] tx_old_r, tx_old_nxt;

  logic          scan_issue, move_issue, read_ok;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_idx, wr_idx;
  slot_t         wr_data, new_slot;
  logic          plan_evict;
  logic [CW-1:0] plan_hole, plan_pos;
  logic          is_report, is_read;

  assign is_report = (item_r.mode == MODE_REPORT) && item_r.name_matches;
  assign is_read   = (item_r.mode == MODE_READ);
  assign read_ok   = IW'(item_r.read_index) < IW'(count_r);

  assign scan_issue = cmd_i.scan && (ptr_r < count_r);
  assign move_issue = cmd_i.move && (mv_left_r != '0);

  // Single read port: scan, move and read requests never overlap.
  assign rd_en  = scan_issue || move_issue || (cmd_i.read_issue && read_ok);
  assign rd_idx = cmd_i.read_issue ? AW'(item_r.read_index) : ptr_r[AW-1:0];

  always_comb begin
    new_slot.address    = item_r.address;
    new_slot.rssi       = item_r.rssi;
    new_slot.tx_power   = item_r.tx_power_present ? item_r.tx_power
                        : (found_r ? tx_old_r : '0);
    new_slot.svc_listed = item_r.svc_listed;
    new_slot.svc_wanted = item_r.svc_listed && item_r.svc_wanted;
  end

  assign wr_en   = wr_pend_r || cmd_i.put;
  assign wr_idx  = cmd_i.put ? pos_r[AW-1:0] : dest_r[AW-1:0];
  assign wr_data = cmd_i.put ? new_slot : rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  // Plan: the table loses one slot (the match, or the weakest on eviction,
  // or a virtual one past the end) and gains the new device at plan_pos.
  always_comb begin
    plan_evict = !found_r && (count_r >= limit_i);
    if (found_r) begin
      plan_hole = k_r;
    end else if (plan_evict) begin
      plan_hole = CW'(count_r - 1'b1);
    end else begin
      plan_hole = count_r;
    end
    if (plan_evict && (ge_r == count_r)) begin
      plan_pos = CW'(count_r - 1'b1);
    end else begin
      plan_pos = ge_r;
    end
  end

  always_comb begin
    ptr_nxt     = ptr_r;
    ge_nxt      = ge_r;
    k_nxt       = k_r;
    found_nxt   = found_r;
    tx_old_nxt  = tx_old_r;
    pos_nxt     = pos_r;
    evict_nxt   = evict_r;
    up_nxt      = up_r;
    mv_left_nxt = mv_left_r;
    dest_nxt    = dest_r;
    count_nxt   = count_r;

    if (cmd_i.capture) begin
      ptr_nxt   = '0;
      ge_nxt    = '0;
      found_nxt = 1'b0;
    end

    if (scan_issue) begin
      ptr_nxt = CW'(ptr_r + 1'b1);
    end

    // Compare the slot read in the previous cycle.
    if (chk_vld_r) begin
      if (rd_data_r.address == item_r.address) begin
        found_nxt  = 1'b1;
        k_nxt      = chk_idx_r;
        tx_old_nxt = rd_data_r.tx_power;
      end else if (rd_data_r.rssi >= item_r.rssi) begin
        ge_nxt = CW'(ge_r + 1'b1);
      end
    end

    if (cmd_i.plan) begin
      pos_nxt   = plan_pos;
      evict_nxt = plan_evict;
      up_nxt    = plan_pos < plan_hole;
      if (plan_pos < plan_hole) begin
        mv_left_nxt = CW'(plan_hole - plan_pos);
        ptr_nxt     = CW'(plan_hole - 1'b1);
      end else begin
        mv_left_nxt = CW'(plan_pos - plan_hole);
        ptr_nxt     = CW'(plan_hole + 1'b1);
      end
    end

    if (move_issue) begin
      mv_left_nxt = CW'(mv_left_r - 1'b1);
      if (up_r) begin
        dest_nxt = CW'(ptr_r + 1'b1);
        ptr_nxt  = CW'(ptr_r - 1'b1);
      end else begin
        dest_nxt = CW'(ptr_r - 1'b1);
        ptr_nxt  = CW'(ptr_r + 1'b1);
      end
    end

    if (cmd_i.put && !found_r && !evict_r) begin
      count_nxt = CW'(count_r + 1'b1);
    end
    if (cmd_i.clear) begin
      count_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      chk_vld_r   <= 1'b0;
      wr_pend_r   <= 1'b0;
      mv_left_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      chk_vld_r   <= scan_issue;
      wr_pend_r   <= move_issue;
      mv_left_r   <= mv_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      item_r <= item_i;
    end
    if (cmd_i.read_issue) begin
      rvalid_r <= read_ok;
    end
    ptr_r     <= ptr_nxt;
    ge_r      <= ge_nxt;
    k_r       <= k_nxt;
    found_r   <= found_nxt;
    tx_old_r  <= tx_old_nxt;
    pos_r     <= pos_nxt;
    evict_r   <= evict_nxt;
    up_r      <= up_nxt;
    dest_r    <= dest_nxt;
    chk_idx_r <= ptr_r;
    if (cmd_i.load_out) begin
      result_r.accepted         <= is_report;
      result_r.evicted          <= is_report && evict_r;
      result_r.position         <= is_report ? IDX_W'(pos_r) : '0;
      result_r.entry_count      <= COUNT_W'(count_r);
      result_r.entry_valid      <= is_read && rvalid_r;
      result_r.entry_address    <= (is_read && rvalid_r) ? rd_data_r.address : '0;
      result_r.entry_rssi       <= (is_read && rvalid_r) ? rd_data_r.rssi : '0;
      result_r.entry_tx_power   <= (is_read && rvalid_r) ? rd_data_r.tx_power : '0;
      result_r.entry_svc_listed <= is_read && rvalid_r && rd_data_r.svc_listed;
      result_r.entry_svc_wanted <= is_read && rvalid_r && rd_data_r.svc_wanted;
    end
  end

  assign result_o  = result_r;
  assign out_valid = out_valid_r;

  assign sts_o.is_report = is_report;
  assign sts_o.is_read   = is_read;
  assign sts_o.is_clear  = (item_r.mode == MODE_CLEAR);
  assign sts_o.scan_done = (ptr_r >= count_r) && !chk_vld_r;
  assign sts_o.move_done = (mv_left_r == '0) && !wr_pend_r;
  assign sts_o.out_free  = !out_valid_r || !out_stall;

  a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && wr_en |-> rd_idx != wr_idx)
    else $error("slot memory read and written at the same index");

  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.put && !found_r && !evict_r |=> count_r == CW'($past(count_r) + 1'b1))
    else $error("new device stored without count increment");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.put |-> count_r <= CW'(TABLE_DEPTH) && pos_r <= count_r)
    else $error("insert position or count out of table bounds");

endmodule

[rtl/core/rssi_sorted_device_table.sv]
// Top level of the RSSI-sorted device table: port packing, the max_entries
// register and its clamp. Depends on rsdt_pkg, rsdt_ctrl and rsdt_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: mode 0 reports an
//   advertisement, mode 1 reads the entry at in_read_index, mode 2 clears the
//   table. Every request yields exactly one result on the output channel
//   (out_valid / out_stall). Configuration writes (cfg_valid / cfg_ready)
//   set max_entries and must be issued only while the block is idle.
// Sequencing:
//   A report makes one search pass over the stored slots and one shifting pass
//   through the single-port slot memory before its result is loaded. One
//   request is in flight at a time; the next is accepted in the cycle after the
//   result is loaded.
// Reset:
//   The table comes up empty and max_entries reads 10. Slot memory is not
//   cleared; only slots below the count are ever read.
// Output stall:
//   The result sits in an output register; the next request is still
//   accepted and processed, then holds until that register drains.
module rssi_sorted_device_table #(
  parameter int TABLE_DEPTH = rsdt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rsdt_pkg::MODE_W-1:0]         in_mode,
  input  logic [rsdt_pkg::ADDR_W-1:0]         in_address,
  input  logic signed [rsdt_pkg::SIG_W-1:0]   in_rssi,
  input  logic                                in_name_matches,
  input  logic                                in_tx_power_present,
  input  logic signed [rsdt_pkg::SIG_W-1:0]   in_tx_power,
  input  logic                                in_svc_listed,
  input  logic                                in_svc_wanted,
  input  logic [rsdt_pkg::IDX_W-1:0]          in_read_index,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rsdt_pkg::MAX_ENT_W-1:0]      cfg_max_entries,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_accepted,
  output logic                                out_evicted,
  output logic [rsdt_pkg::IDX_W-1:0]          out_position,
  output logic [rsdt_pkg::COUNT_W-1:0]        out_entry_count,
  output logic                                out_entry_valid,
  output logic [rsdt_pkg::ADDR_W-1:0]         out_entry_address,
  output logic signed [rsdt_pkg::SIG_W-1:0]   out_entry_rssi,
  output logic signed [rsdt_pkg::SIG_W-1:0]   out_entry_tx_power,
  output logic                                out_entry_svc_listed,
  output logic                                out_entry_svc_wanted
);
  import rsdt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [MAX_ENT_W-1:0] max_entries_r;
  logic [CW-1:0]        limit;
  dp_cmd_t              cmd;
  dp_sts_t              sts;
  item_t                item;
  result_t              result;

  // Configuration must only be written while idle; the block does not enforce this, so always take it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= MAX_ENT_W'(MAX_ENTRIES_RESET);
    end else if (cfg_valid && cfg_ready) begin
      max_entries_r <= cfg_max_entries;
    end
  end

  // Clamp the limit to 1 .. TABLE_DEPTH.
  always_comb begin
    if (max_entries_r == '0) begin
      limit = CW'(1);
    end else if (int'(max_entries_r) > TABLE_DEPTH) begin
      limit = CW'(TABLE_DEPTH);
    end else begin
      limit = CW'(max_entries_r);
    end
  end

  always_comb begin
    item.mode             = in_mode;
    item.address          = in_address;
    item.rssi             = in_rssi;
    item.name_matches     = in_name_matches;
    item.tx_power_present = in_tx_power_present;
    item.tx_power         = in_tx_power;
    item.svc_listed       = in_svc_listed;
    item.svc_wanted       = in_svc_wanted;
    item.read_index       = in_read_index;
  end

  rsdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  rsdt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .limit_i   (limit),
    .item_i    (item),
    .result_o  (result),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  assign out_accepted         = result.accepted;
  assign out_evicted          = result.evicted;
  assign out_position         = result.position;
  assign out_entry_count      = result.entry_count;
  assign out_entry_valid      = result.entry_valid;
  assign out_entry_address    = result.entry_address;
  assign out_entry_rssi       = result.entry_rssi;
  assign out_entry_tx_power   = result.entry_tx_power;
  assign out_entry_svc_listed = result.entry_svc_listed;
  assign out_entry_svc_wanted = result.entry_svc_wanted;

endmodule

[verif/device_table_checker.sv]
// Checker for the RSSI-sorted device table: watches the request, result and limit channels,
// keeps its own copy of the sorted table and compares every result with its prediction.
// Depends on rsdt_pkg for the request and result layouts.
module device_table_checker #(
  parameter int DEPTH = rsdt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  rsdt_pkg::item_t                in_req,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rsdt_pkg::MAX_ENT_W-1:0] cfg_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  rsdt_pkg::result_t              out_rsp,
  output int                             fail_count,
  output int                             pending_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import rsdt_pkg::*;

  logic [MAX_ENT_W-1:0] limit_reg;
  int                   stored;
  logic [ADDR_W-1:0]    dev_addr [DEPTH];
  int                   dev_rssi [DEPTH];
  int                   dev_txp  [DEPTH];
  logic                 dev_svc  [DEPTH];
  logic                 dev_want [DEPTH];
  result_t              expected_results [$];

  function automatic int effective_limit();
    if (limit_reg == 0) return 1;
    if (limit_reg > DEPTH) return DEPTH;
    return int'(limit_reg);
  endfunction

  // Update the table copy for one request and work out the result it must give.
  task automatic apply_request(input item_t rq, output result_t res);
    int  hit;
    int  pos;
    int  txp;
    bit  found;
    res   = '0;
    found = 1'b0;
    hit   = 0;
    txp   = 0;
    pos   = 0;
    if (rq.mode == MODE_REPORT && rq.name_matches) begin
      for (int i = 0; i < stored; i++) begin
        if (!found && dev_addr[i] == rq.address) begin
          found = 1'b1;
          hit   = i;
          txp   = dev_txp[i];
        end
      end
      if (found) begin
        for (int i = hit; i + 1 < stored; i++) begin
          dev_addr[i] = dev_addr[i+1];
          dev_rssi[i] = dev_rssi[i+1];
          dev_txp[i]  = dev_txp[i+1];
          dev_svc[i]  = dev_svc[i+1];
          dev_want[i] = dev_want[i+1];
        end
        stored--;
      end else if (stored >= effective_limit() && stored > 0) begin
        stored--;
        res.evicted = 1'b1;
      end
      if (rq.tx_power_present) txp = int'(rq.tx_power);
      while (pos < stored && dev_rssi[pos] >= int'(rq.rssi)) pos++;
      for (int i = stored; i > pos; i--) begin
        dev_addr[i] = dev_addr[i-1];
        dev_rssi[i] = dev_rssi[i-1];
        dev_txp[i]  = dev_txp[i-1];
        dev_svc[i]  = dev_svc[i-1];
        dev_want[i] = dev_want[i-1];
      end
      dev_addr[pos] = rq.address;
      dev_rssi[pos] = int'(rq.rssi);
      dev_txp[pos]  = txp;
      dev_svc[pos]  = rq.svc_listed;
      dev_want[pos] = rq.svc_listed & rq.svc_wanted;
      stored++;
      res.accepted = 1'b1;
      res.position = IDX_W'(pos);
    end else if (rq.mode == MODE_READ) begin
      if (int'(rq.read_index) < stored) begin
        res.entry_valid      = 1'b1;
        res.entry_address    = dev_addr[rq.read_index];
        res.entry_rssi       = SIG_W'(dev_rssi[rq.read_index]);
        res.entry_tx_power   = SIG_W'(dev_txp[rq.read_index]);
        res.entry_svc_listed = dev_svc[rq.read_index];
        res.entry_svc_wanted = dev_want[rq.read_index];
      end
    end else if (rq.mode == MODE_CLEAR) begin
      stored = 0;
    end
    res.entry_count = COUNT_W'(stored);
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("result field %s: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t fresh;
    if (!rst_n) begin
      limit_reg = MAX_ENT_W'(MAX_ENTRIES_RESET);
      stored    = 0;
      expected_results.delete();
    end else begin
      // Retire the result first: it always belongs to an earlier request.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request waiting for it");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("accepted", want.accepted, out_rsp.accepted);
          compare_field("evicted", want.evicted, out_rsp.evicted);
          compare_field("position", want.position, out_rsp.position);
          compare_field("entry_count", want.entry_count, out_rsp.entry_count);
          compare_field("entry_valid", want.entry_valid, out_rsp.entry_valid);
          compare_field("entry_address", want.entry_address, out_rsp.entry_address);
          compare_field("entry_rssi", want.entry_rssi, out_rsp.entry_rssi);
          compare_field("entry_tx_power", want.entry_tx_power, out_rsp.entry_tx_power);
          compare_field("entry_svc_listed", want.entry_svc_listed,
                        out_rsp.entry_svc_listed);
          compare_field("entry_svc_wanted", want.entry_svc_wanted,
                        out_rsp.entry_svc_wanted);
        end
      end
      if (cfg_valid && cfg_ready) limit_reg = cfg_data;
      if (in_valid && !in_stall) begin
        apply_request(in_req, fresh);
        expected_results.push_back(fresh);
      end
    end
    pending_results = expected_results.size();
  end

endmodule

[verif/testbench.sv]
// Top of the device table testbench: clock, reset, request and limit stimulus, result stalls
// and the verdict. Depends on rsdt_pkg, rssi_sorted_device_table and device_table_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rsdt_pkg::*;

  // Mode 3 has no name in the package; the block must ignore it.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_TOP    = '1;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int POOL_SIZE       = 20;
  localparam int LONG_HOLD       = 400;
  localparam int DRAIN_CYCLES    = 60;
  localparam int LIMIT_CYCLES    = 600000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  item_t                req;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [MAX_ENT_W-1:0] cfg_max_entries;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_accepted;
  logic                 out_evicted;
  logic [IDX_W-1:0]     out_position;
  logic [COUNT_W-1:0]   out_entry_count;
  logic                 out_entry_valid;
  logic [ADDR_W-1:0]    out_entry_address;
  logic signed [SIG_W-1:0] out_entry_rssi;
  logic signed [SIG_W-1:0] out_entry_tx_power;
  logic                 out_entry_svc_listed;
  logic                 out_entry_svc_wanted;
  result_t              rsp;

  int                   fail_count;
  int                   pending_results;
  int                   cycles = 0;
  bit                   quiet;
  bit                   long_hold;
  logic [ADDR_W-1:0]    addr_pool [POOL_SIZE];

  always #5 clk = ~clk;

  assign rsp = {out_accepted, out_evicted, out_position, out_entry_count, out_entry_valid,
                out_entry_address, out_entry_rssi, out_entry_tx_power,
                out_entry_svc_listed, out_entry_svc_wanted};

  rssi_sorted_device_table dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (req.mode),
    .in_address           (req.address),
    .in_rssi              (req.rssi),
    .in_name_matches      (req.name_matches),
    .in_tx_power_present  (req.tx_power_present),
    .in_tx_power          (req.tx_power),
    .in_svc_listed        (req.svc_listed),
    .in_svc_wanted        (req.svc_wanted),
    .in_read_index        (req.read_index),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_max_entries      (cfg_max_entries),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_accepted         (out_accepted),
    .out_evicted          (out_evicted),
    .out_position         (out_position),
    .out_entry_count      (out_entry_count),
    .out_entry_valid      (out_entry_valid),
    .out_entry_address    (out_entry_address),
    .out_entry_rssi       (out_entry_rssi),
    .out_entry_tx_power   (out_entry_tx_power),
    .out_entry_svc_listed (out_entry_svc_listed),
    .out_entry_svc_wanted (out_entry_svc_wanted)
  );

  device_table_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req          (req),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_max_entries),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rsp         (rsp),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Build one request from its fields; fields a mode ignores still get driven.
  function automatic item_t build(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                                  input int rssi, input bit named, input bit has_tx,
                                  input int tx, input bit svc, input bit want, input int idx);
    item_t r;
    r.mode             = mode;
    r.address          = addr;
    r.rssi             = SIG_W'(rssi);
    r.name_matches     = named;
    r.tx_power_present = has_tx;
    r.tx_power         = SIG_W'(tx);
    r.svc_listed       = svc;
    r.svc_wanted       = want;
    r.read_index       = IDX_W'(idx);
    return r;
  endfunction

  // Mostly matched reports over a small address pool so that devices come back,
  // with reads, the odd clear, ignored modes and rejected names as noise.
  function automatic item_t random_request();
    item_t       r;
    int          pick;
    logic [63:0] wide;
    wide                = {$urandom(), $urandom()};
    r.address           = ($urandom_range(0, 99) < 85) ?
                          addr_pool[$urandom_range(0, POOL_SIZE-1)] : wide[ADDR_W-1:0];
    // Cluster many strengths so that ties with stored entries are common.
    r.rssi              = ($urandom_range(0, 9) < 4) ? SIG_W'(-60 + $urandom_range(0, 6) - 3)
                                                     : SIG_W'($urandom());
    r.name_matches      = ($urandom_range(0, 9) != 0);
    r.tx_power_present  = 1'($urandom_range(0, 1));
    r.tx_power          = SIG_W'($urandom());
    r.svc_listed        = 1'($urandom_range(0, 1));
    r.svc_wanted        = 1'($urandom_range(0, 1));
    r.read_index        = IDX_W'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 65)      r.mode = MODE_REPORT;
    else if (pick < 90) r.mode = MODE_READ;
    else if (pick < 94) r.mode = MODE_CLEAR;
    else                r.mode = MODE_UNUSED;
    return r;
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input item_t r);
    @(negedge clk);
    req      <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic drain();
    pause_sender(1);
    while (pending_results != 0) @(negedge clk);
  endtask

  // Write max_entries; only legal with the block idle, so drain first.
  task automatic write_limit(input int value);
    drain();
    cfg_valid       <= 1'b1;
    cfg_max_entries <= MAX_ENT_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int phase_limit(input int phase);
    case (phase)
      0:       return 16;
      1:       return 2;   // drop well below what phase 0 left stored
      2:       return 0;   // acts as a one-entry table
      3:       return 31;  // clamps to the table depth
      4:       return 1;
      6:       return MAX_ENTRIES_RESET;
      default: return $urandom_range(0, 31);
    endcase
  endfunction

  // Result side: random stall bursts, one long hold on request, none at the end.
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        // Hold off long enough for the block to fill its output and stall its input.
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (quiet || $urandom_range(0, 1) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 30)) @(negedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [63:0] wide;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    req             = '0;
    cfg_valid       = 1'b0;
    cfg_max_entries = '0;
    quiet           = 1'b0;
    long_hold       = 1'b0;
    addr_pool[0] = '0;
    addr_pool[1] = ADDR_TOP;
    for (int i = 2; i < POOL_SIZE; i++) begin
      wide = {$urandom(), $urandom()};
      addr_pool[i] = wide[ADDR_W-1:0];
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, default limit of ten.
    // Read from the empty table: out of range.
    send_request(build(MODE_READ, '0, 0, 0, 0, 0, 0, 0, 0));
    // Rejected report: name prefix missing, nothing stored.
    send_request(build(MODE_REPORT, ADDR_TOP, 127, 0, 1, 127, 1, 1, 15));
    // New device without tx power gets zero; wanted service without a service list drops.
    send_request(build(MODE_REPORT, '0, -128, 1, 0, 55, 0, 1, 0));
    send_request(build(MODE_REPORT, ADDR_TOP, 127, 1, 1, 127, 1, 1, 0));
    // Equal strength lands after the existing entry.
    send_request(build(MODE_REPORT, 48'h0000_A5A5_0001, 127, 1, 1, -128, 1, 0, 0));
    // Known device without tx power keeps its stored power and moves down.
    send_request(build(MODE_REPORT, ADDR_TOP, -1, 1, 0, 0, 1, 1, 0));
    // Unused mode: only the count comes back.
    send_request(build(MODE_UNUSED, ADDR_TOP, 0, 1, 1, 0, 1, 1, 15));
    send_request(build(MODE_READ, '0, 0, 0, 0, 0, 0, 0, 0));
    send_request(build(MODE_READ, '0, 0, 0, 0, 0, 0, 0, 1));
    send_request(build(MODE_READ, '0, 0, 0, 0, 0, 0, 0, 2));
    send_request(build(MODE_READ, '0, 0, 0, 0, 0, 0, 0, 15));

    // Lower the limit under the count: each new device evicts only the weakest.
    write_limit(1);
    send_request(build(MODE_REPORT, 48'h5A5A_0000_0002, 5, 1, 1, 3, 1, 0, 0));
    send_request(build(MODE_CLEAR, '0, 0, 0, 0, 0, 0, 0, 0));
    send_request(build(MODE_REPORT, 48'h0000_0000_0111, -40, 1, 1, -4, 0, 0, 0));
    // One-entry table full: the only entry goes.
    send_request(build(MODE_REPORT, 48'h0000_0000_0222, -80, 1, 1, 9, 1, 1, 0));
    send_request(build(MODE_READ, '0, 0, 0, 0, 0, 0, 0, 0));
    send_request(build(MODE_READ, '0, 0, 0, 0, 0, 0, 0, 1));

    // A limit of zero behaves as one.
    write_limit(0);
    send_request(build(MODE_REPORT, 48'h0000_0000_0333, 20, 1, 1, 1, 1, 0, 0));
    send_request(build(MODE_REPORT, 48'h0000_0000_0333, 30, 1, 0, 0, 0, 1, 0));
    send_request(build(MODE_READ, '0, 0, 0, 0, 0, 0, 0, 0));

    // Random phases; each limit change waits for the block to go idle.
    for (int phase = 0; phase < PHASES; phase++) begin
      write_limit(phase_limit(phase));
      if (phase == 3) long_hold = 1'b1;
      if (phase == PHASES - 1) quiet = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (!quiet && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 17));
        send_request(random_request());
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
